@@ src/plsu_pkg.sv @@
// plsu_pkg: shared types and codes for the positional list store
// request and response payload structs, command and status codes, defaults
// no dependencies
package plsu_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   // memory port strobes from the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // finished command handed from the sequencer to the response stage
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic                is_read;
   } done_type;

endpackage

@@ src/plsu_ram.sv @@
// plsu_ram: entry storage, one write port and one registered read port
// depends on plsu_pkg
module plsu_ram
   import plsu_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  mem_ctl_type           mem_ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not strobed
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/plsu_ctrl.sv @@
// plsu_ctrl: command sequencer with the shared pointer step and compare unit
// checks each request, keeps the entry count and walks the memory to shift entries
// depends on plsu_pkg
module plsu_ctrl
   import plsu_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW        = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_free,
   output done_type              done,
   output logic [CW-1:0]         count,
   output mem_ctl_type           mem_ctl,
   output logic [AW-1:0]         wr_addr,
   output logic [DATA_WIDTH-1:0] wr_data,
   output logic [AW-1:0]         rd_addr,
   input  logic [DATA_WIDTH-1:0] rd_data
);

   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_PLACE  = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [AW-1:0]         lim_ff, lim_in;
   logic                  down_ff, down_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  is_read_ff, is_read_in;

   logic                  accept;
   logic [CMPW-1:0]       pos_c;
   logic [CMPW-1:0]       cnt_c;
   logic                  full;
   logic                  empty;
   logic [STATUS_W-1:0]   req_status;
   logic [AW-1:0]         ptr_nxt;
   logic                  ptr_at_lim;
   logic [DATA_WIDTH-1:0] req_word;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign pos_c    = CMPW'(req_data.position);
   assign cnt_c    = CMPW'(count_ff);
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign req_word = DATA_WIDTH'($unsigned(req_data.value));

   // shared pointer unit: one step up or down and the end compare
   assign ptr_nxt    = down_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
   assign ptr_at_lim = (ptr_ff == lim_ff);

   // request check
   always_comb begin
      req_status = ST_OK;
      case (req_data.cmd)
         CMD_APPEND: begin
            if (full) req_status = ST_FULL;
         end
         CMD_INSERT: begin
            if (pos_c > cnt_c) req_status = ST_BADPOS;
            else if (full)     req_status = ST_FULL;
         end
         default: begin
            if (empty)              req_status = ST_EMPTY;
            else if (pos_c >= cnt_c) req_status = ST_BADPOS;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      dst_in     = dst_ff;
      lim_in     = lim_ff;
      down_in    = down_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      is_read_in = is_read_ff;
      mem_ctl    = '0;
      wr_addr    = dst_ff;
      wr_data    = rd_data;
      rd_addr    = ptr_nxt;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in     = req_word;
               status_in  = req_status;
               is_read_in = (req_data.cmd == CMD_READ);
               state_in   = S_FINISH;
               if (req_status == ST_OK) begin
                  case (req_data.cmd)
                     CMD_APPEND: begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = AW'(count_ff);
                        wr_data       = req_word;
                        count_in      = count_ff + CW'(1);
                     end
                     CMD_INSERT: begin
                        count_in = count_ff + CW'(1);
                        if (pos_c == cnt_c) begin
                           mem_ctl.wr_en = 1'b1;
                           wr_addr       = AW'(req_data.position);
                           wr_data       = req_word;
                        end else begin
                           mem_ctl.rd_en = 1'b1;
                           rd_addr       = AW'(count_ff - CW'(1));
                           ptr_in        = AW'(count_ff - CW'(1));
                           dst_in        = AW'(count_ff);
                           lim_in        = AW'(req_data.position);
                           down_in       = 1'b1;
                           state_in      = S_SHIFT;
                        end
                     end
                     CMD_DELETE: begin
                        count_in = count_ff - CW'(1);
                        if (pos_c != cnt_c - CMPW'(1)) begin
                           mem_ctl.rd_en = 1'b1;
                           rd_addr       = AW'(pos_c + CMPW'(1));
                           ptr_in        = AW'(pos_c + CMPW'(1));
                           dst_in        = AW'(req_data.position);
                           lim_in        = AW'(count_ff - CW'(1));
                           down_in       = 1'b0;
                           state_in      = S_SHIFT;
                        end
                     end
                     default: begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(req_data.position);
                        state_in      = S_RDWAIT;
                     end
                  endcase
               end
            end
         end
         S_SHIFT: begin
            // move the word read last cycle, fetch the next one
            mem_ctl.wr_en = 1'b1;
            wr_addr       = dst_ff;
            wr_data       = rd_data;
            if (ptr_at_lim) begin
               state_in = down_ff ? S_PLACE : S_FINISH;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = ptr_nxt;
               ptr_in        = ptr_nxt;
               dst_in        = ptr_ff;
            end
         end
         S_PLACE: begin
            // new word into the opened slot
            mem_ctl.wr_en = 1'b1;
            wr_addr       = lim_ff;
            wr_data       = val_ff;
            state_in      = S_FINISH;
         end
         S_RDWAIT: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      dst_ff     <= dst_in;
      lim_ff     <= lim_in;
      down_ff    <= down_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      is_read_ff <= is_read_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign done.valid   = (state_ff == S_FINISH);
   assign done.status  = status_ff;
   assign done.is_read = is_read_ff;
   assign count        = count_ff;

endmodule

@@ src/positional_list_store_unit.sv @@
// positional_list_store_unit: ordered list of signed words with indexed access
// top level: sequencer, entry memory and response register
// depends on plsu_pkg, plsu_ram, plsu_ctrl
//
//   channel   ports                         moves
//   request   req_valid req_ready req_data  cmd, position, value
//   response  rsp_valid rsp_ready rsp_data  status, count, read_value
//
// append and refused commands finish straight from accept; read waits on the registered read port
// insert and delete that move entries walk the memory one entry at a time through the single
// write port, and an insert then places the new word in the opened slot;
// insert at the end and delete of the last entry move nothing and finish straight from accept
// reset clears the entry count, the sequencer state and the response valid; the memory is not cleared
// a stalled response holds the next finished command in the sequencer, no new request
// is taken until the response register frees
module positional_list_store_unit
   import plsu_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int EXTW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   done_type              done;
   logic [CW-1:0]         count;
   logic                  rsp_free;
   logic [EXTW-1:0]       rd_ext;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   plsu_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .done      (done),
      .count     (count),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   plsu_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sign extension of the stored word
   assign rd_ext   = EXTW'($signed(rd_data));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done.valid && rsp_free) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = done.status;
         rsp_data_in.count  = COUNT_W'(count);
         if (done.is_read && (done.status == ST_OK)) begin
            rsp_data_in.read_value = rd_ext[VALUE_W-1:0];
         end else begin
            rsp_data_in.read_value = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ test/tb_positional_list_store_unit.sv @@
`timescale 1ns / 1ps
// tb_positional_list_store_unit: self-checking bench for the positional list store
// predicts every response from a local copy of the list, with bursty requests and stalls
// depends on plsu_pkg and positional_list_store_unit
module tb_positional_list_store_unit;
   import plsu_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1880;
   localparam int REPORT_CAP   = 200;

   typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PATTERN} sink_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // local copy of the list contents
   logic signed [VALUE_W-1:0] list_words [DEPTH_DEF];
   int                        list_len = 0;
   rsp_type                   expected_rsp_q [$];

   int            mismatches  = 0;
   int            cycle_count = 0;
   int            burst_left  = 0;
   int            sink_left   = 0;
   int            sink_tick   = 0;
   sink_mode_type sink_mode   = SINK_OPEN;

   positional_list_store_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // apply one command to the local list and return its response
   function automatic rsp_type apply_list_command(input req_type r);
      rsp_type o;
      int      slot;
      o        = '0;
      o.status = ST_OK;
      case (r.cmd)
         CMD_APPEND: begin
            if (list_len >= DEPTH_DEF) begin
               o.status = ST_FULL;
            end else begin
               list_words[list_len] = r.value;
               list_len++;
            end
         end
         CMD_INSERT: begin
            // position check comes before the full check
            if (int'(r.position) > list_len) begin
               o.status = ST_BADPOS;
            end else if (list_len >= DEPTH_DEF) begin
               o.status = ST_FULL;
            end else begin
               for (slot = list_len; slot > int'(r.position); slot--)
                  list_words[slot] = list_words[slot-1];
               list_words[r.position] = r.value;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else if (int'(r.position) >= list_len) begin
               o.status = ST_BADPOS;
            end else begin
               for (slot = int'(r.position); slot + 1 < list_len; slot++)
                  list_words[slot] = list_words[slot+1];
               list_len--;
            end
         end
         default: begin
            if (list_len == 0) begin
               o.status = ST_EMPTY;
            end else if (int'(r.position) >= list_len) begin
               o.status = ST_BADPOS;
            end else begin
               o.read_value = list_words[r.position];
            end
         end
      endcase
      o.count = list_len[COUNT_W-1:0];
      return o;
   endfunction

   // random word, leaning on the extremes now and then
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(VALUE_W-1){1'b0}}};
         1:       return {1'b0, {(VALUE_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // drive one request, hold it until accepted, then record its expected response
   task automatic send_request(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                               input logic signed [VALUE_W-1:0] v);
      req_type item;
      int      gap;
      item.cmd      = c;
      item.position = p;
      item.value    = v;
      // idle gap between bursts
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rsp_q.push_back(apply_list_command(item));
      burst_left--;
   endtask

   // read and delete on an empty list, insert past the end
   task automatic test_empty_list();
      send_request(CMD_READ, 5'd0, '0);
      send_request(CMD_DELETE, 5'd31, '1);
      send_request(CMD_INSERT, 5'd1, 32'sd5);
   endtask

   // fill to DEPTH with extreme words, then try to grow past it
   task automatic test_full_list();
      int k;
      send_request(CMD_INSERT, 5'd0, {1'b1, {(VALUE_W-1){1'b0}}});
      for (k = 1; k < DEPTH_DEF; k++) begin
         case (k % 4)
            0:       send_request(CMD_APPEND, 5'd31, 32'sh5555_5555);
            1:       send_request(CMD_APPEND, 5'd0, {1'b0, {(VALUE_W-1){1'b1}}});
            2:       send_request(CMD_APPEND, 5'd16, '1);
            default: send_request(CMD_APPEND, 5'd7, 32'shAAAA_AAAA);
         endcase
      end
      send_request(CMD_APPEND, 5'd0, 32'sd1);
      send_request(CMD_INSERT, 5'd16, 32'sd2);
      send_request(CMD_INSERT, 5'd17, 32'sd3);
   endtask

   // reads and edits at the first and last positions
   task automatic test_edge_positions();
      send_request(CMD_READ, 5'd15, '0);
      send_request(CMD_READ, 5'd16, '0);
      send_request(CMD_DELETE, 5'd0, '0);
      send_request(CMD_INSERT, 5'd15, 32'sh0F0F_0F0F);
      send_request(CMD_READ, 5'd0, '0);
      send_request(CMD_DELETE, 5'd15, '0);
   endtask

   // random walk that swings the list between empty and full
   task automatic test_random_mix(input int n);
      int k;
      int roll;
      bit growing;
      logic [POS_W-1:0] pos_any;
      logic [POS_W-1:0] pos_in;
      logic [POS_W-1:0] pos_gap;
      growing = 1'b1;
      for (k = 0; k < n; k++) begin
         // linger at full or empty so refusals get exercised
         if (list_len == DEPTH_DEF && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (list_len == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;
         else if ($urandom_range(0, 47) == 0)
            growing = !growing;
         pos_any = POS_W'($urandom_range(0, 31));
         pos_in  = (list_len > 0) ? POS_W'($urandom_range(0, list_len - 1)) : '0;
         pos_gap = POS_W'($urandom_range(0, list_len));
         roll    = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any command at any position
            send_request(CMD_W'($urandom_range(0, 3)), pos_any, pick_value());
         end else if (growing) begin
            if (roll < 45)      send_request(CMD_APPEND, pos_any, pick_value());
            else if (roll < 70) send_request(CMD_INSERT, pos_gap, pick_value());
            else if (roll < 88) send_request(CMD_READ, pos_in, pick_value());
            else                send_request(CMD_DELETE, pos_in, pick_value());
         end else begin
            if (roll < 50)      send_request(CMD_DELETE, pos_in, pick_value());
            else if (roll < 75) send_request(CMD_READ, pos_in, pick_value());
            else if (roll < 88) send_request(CMD_INSERT, pos_gap, pick_value());
            else                send_request(CMD_APPEND, pos_any, pick_value());
         end
      end
   endtask

   // response side stalls on its own changing pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 160);
         end
         sink_left--;
         sink_tick++;
         case (sink_mode)
            SINK_OPEN:   rsp_ready <= 1'b1;
            SINK_COIN:   rsp_ready <= ($urandom_range(0, 1) == 0);
            SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ready <= ((sink_tick % 6) < 2);
         endcase
      end
   end

   // compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
            end
            if (rsp_data.count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: count expected %0d actual %0d", $time,
                           want.count, rsp_data.count);
            end
            if (rsp_data.read_value !== want.read_value) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           want.read_value, rsp_data.read_value);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_full_list();
      test_edge_positions();
      test_random_mix(RANDOM_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DEPTH_DEF + 8) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
src/plsu_pkg.sv
src/plsu_ram.sv
src/plsu_ctrl.sv
src/positional_list_store_unit.sv
test/tb_positional_list_store_unit.sv
